// File: src/pm0_pkg.sv
// ----------------------------------------------------------------------------
// pm0_pkg
// Shared types and constants for the PM/0 stack machine execute core.
// ----------------------------------------------------------------------------
package pm0_pkg;

    localparam int DATA_W = 32;
    localparam int EXT_W  = 34;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LIT   = 4'd1,
        OP_OPR   = 4'd2,
        OP_LOD   = 4'd3,
        OP_STO   = 4'd4,
        OP_CAL   = 4'd5,
        OP_INC   = 4'd6,
        OP_JMP   = 4'd7,
        OP_JPC   = 4'd8,
        OP_WRITE = 4'd9,
        OP_READ  = 4'd10,
        OP_HALT  = 4'd11
    } op_t;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_DIV0  = 2'd1,
        FLT_OVER  = 2'd2,
        FLT_UNDER = 2'd3
    } fault_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_WALK,
        S_WALK_RD,
        S_LOD_WR,
        S_STO_WR,
        S_CAL2,
        S_CAL3,
        S_CAL4,
        S_RET1,
        S_RET2,
        S_UN,
        S_BIN1,
        S_BIN2,
        S_DIV,
        S_DIV_END,
        S_JW,
        S_TOP,
        S_TOP_RD,
        S_FIN
    } state_t;

    localparam logic [31:0] OPR_RET = 32'd0;
    localparam logic [31:0] OPR_NEG = 32'd1;
    localparam logic [31:0] OPR_ADD = 32'd2;
    localparam logic [31:0] OPR_SUB = 32'd3;
    localparam logic [31:0] OPR_MUL = 32'd4;
    localparam logic [31:0] OPR_DIV = 32'd5;
    localparam logic [31:0] OPR_ODD = 32'd6;
    localparam logic [31:0] OPR_MOD = 32'd7;
    localparam logic [31:0] OPR_EQL = 32'd8;
    localparam logic [31:0] OPR_NEQ = 32'd9;
    localparam logic [31:0] OPR_LSS = 32'd10;
    localparam logic [31:0] OPR_LEQ = 32'd11;
    localparam logic [31:0] OPR_GTR = 32'd12;
    localparam logic [31:0] OPR_GEQ = 32'd13;

    function automatic fault_t addr_fault(input logic signed [EXT_W-1:0] a,
                                          input logic signed [EXT_W-1:0] depth);
        fault_t f;
        begin
            if (a < 0)
                f = FLT_OVER;
            else if (a >= depth)
                f = FLT_UNDER;
            else
                f = FLT_NONE;
            return f;
        end
    endfunction

endpackage

// File: src/pm0_stack_machine_execute_core.sv
// ----------------------------------------------------------------------------
// pm0_stack_machine_execute_core
// PM/0 P-machine execute stage: one instruction per request, state held in a
// single-port-read, single-port-write stack memory.
// ----------------------------------------------------------------------------
// After reset the core sweeps the stack memory to zero, one entry per cycle,
// with in_stall high. Each instruction then runs through a sequencer around
// the stack memory (one read and one write per cycle, registered read data).
// A static-link walk reads one link per level, div or mod with a nonzero
// divisor runs through the bit-serial divider, and a result with an empty
// stack or a write skips the top-of-stack read. A range fault stops the
// sequence at the failing check; a divide by zero still pops both operands
// and pushes zero. A new request is taken while the previous result is still
// held.
module pm0_stack_machine_execute_core #(
    parameter int STACK_DEPTH = 1024,
    parameter int CODE_DEPTH  = 512,
    parameter int MAX_LEVEL   = 15,
    localparam int SB_W = $clog2(STACK_DEPTH),
    localparam int SP_W = $clog2(STACK_DEPTH + 1),
    localparam int PC_W = $clog2(CODE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          command,
    input  logic [3:0]          level,
    input  logic signed [31:0]  operand,
    input  logic signed [31:0]  read_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PC_W-1:0]     next_pc,
    output logic [SB_W-1:0]     frame_base,
    output logic [SP_W-1:0]     stack_index,
    output logic signed [31:0]  top_value,
    output logic                print_valid,
    output logic                halted,
    output logic [1:0]          fault
);

    localparam logic signed [pm0_pkg::EXT_W-1:0] DEPTH_S = pm0_pkg::EXT_W'(STACK_DEPTH);

    pm0_pkg::state_t state_reg, state_next;
    pm0_pkg::op_t    op_reg, op_next;
    pm0_pkg::fault_t fault_reg, fault_next, chk_fault;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [SB_W-1:0] bp_reg, bp_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic            halt_reg, halt_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [31:0]     m_reg, m_next;
    logic [31:0]     rv_reg, rv_next;
    logic signed [pm0_pkg::EXT_W-1:0] b_reg, b_next;
    logic [SB_W-1:0] addr_reg, addr_next;
    logic [31:0]     rop_reg, rop_next;
    logic            pv_reg, pv_next;
    logic [31:0]     tv_reg, tv_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     quo_reg, quo_next;
    logic [4:0]      dcnt_reg, dcnt_next;
    logic            negq_reg, negq_next;
    logic            negr_reg, negr_next;
    logic [SB_W-1:0] clr_reg, clr_next;

    logic            ovalid_reg, ovalid_next;
    logic [PC_W-1:0] opc_reg, opc_next;
    logic [SB_W-1:0] obp_reg, obp_next;
    logic [SP_W-1:0] osp_reg, osp_next;
    logic [31:0]     otv_reg, otv_next;
    logic            opv_reg, opv_next;
    logic            ohalt_reg, ohalt_next;
    logic [1:0]      oflt_reg, oflt_next;

    logic [31:0]     stack_mem [STACK_DEPTH];
    logic [31:0]     mem_rdata_reg;
    logic            mem_we;
    logic [SB_W-1:0] mem_waddr;
    logic [31:0]     mem_wdata;
    logic [SB_W-1:0] mem_raddr;

    logic signed [pm0_pkg::EXT_W-1:0] sxm, sp_s, walk_prev, walk_a, inc_a, ret_nb;
    logic [SP_W-1:0] sp_m1, sp_p1;
    logic            is_bin, is_un;

    assign sxm       = signed'({{2{m_reg[31]}}, m_reg});
    assign sp_s      = signed'({{(pm0_pkg::EXT_W - SP_W){1'b0}}, sp_reg});
    assign walk_prev = b_reg - pm0_pkg::EXT_W'(1);
    assign walk_a    = b_reg - sxm;
    assign inc_a     = sp_s - sxm;
    assign ret_nb    = signed'({{2{mem_rdata_reg[31]}}, mem_rdata_reg});
    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_p1     = sp_reg + SP_W'(1);
    assign is_un     = (m_reg == pm0_pkg::OPR_NEG) || (m_reg == pm0_pkg::OPR_ODD);
    assign is_bin    = m_reg inside {pm0_pkg::OPR_ADD, pm0_pkg::OPR_SUB, pm0_pkg::OPR_MUL,
                                     pm0_pkg::OPR_DIV, pm0_pkg::OPR_MOD, pm0_pkg::OPR_EQL,
                                     pm0_pkg::OPR_NEQ, pm0_pkg::OPR_LSS, pm0_pkg::OPR_LEQ,
                                     pm0_pkg::OPR_GTR, pm0_pkg::OPR_GEQ};

    // stack memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= stack_mem[mem_raddr];
    end

    // fault checks of the current step
    always_comb
    begin
        chk_fault = pm0_pkg::FLT_NONE;
        case (state_reg)
            pm0_pkg::S_DEC:
            begin
                if (!halt_reg)
                begin
                    case (op_reg)
                        pm0_pkg::OP_LIT, pm0_pkg::OP_READ, pm0_pkg::OP_LOD:
                            if (sp_reg == '0) chk_fault = pm0_pkg::FLT_OVER;
                        pm0_pkg::OP_OPR:
                        begin
                            if (m_reg == pm0_pkg::OPR_RET)
                            begin
                                if (bp_reg < SB_W'(3)) chk_fault = pm0_pkg::FLT_OVER;
                            end
                            else if (is_un)
                            begin
                                if (sp_reg >= SP_W'(STACK_DEPTH))
                                    chk_fault = pm0_pkg::FLT_UNDER;
                            end
                            else if (is_bin)
                            begin
                                if (sp_reg > SP_W'(STACK_DEPTH - 2))
                                    chk_fault = pm0_pkg::FLT_UNDER;
                            end
                        end
                        pm0_pkg::OP_STO, pm0_pkg::OP_JPC, pm0_pkg::OP_WRITE:
                            if (sp_reg >= SP_W'(STACK_DEPTH)) chk_fault = pm0_pkg::FLT_UNDER;
                        pm0_pkg::OP_CAL:
                            if (sp_reg < SP_W'(4)) chk_fault = pm0_pkg::FLT_OVER;
                        pm0_pkg::OP_INC:
                        begin
                            if (inc_a < 0)
                                chk_fault = pm0_pkg::FLT_OVER;
                            else if (inc_a > DEPTH_S)
                                chk_fault = pm0_pkg::FLT_UNDER;
                        end
                        default:
                            chk_fault = pm0_pkg::FLT_NONE;
                    endcase
                end
            end
            pm0_pkg::S_WALK:
            begin
                if (cnt_reg != 4'd0)
                    chk_fault = pm0_pkg::addr_fault(walk_prev, DEPTH_S);
                else if (op_reg == pm0_pkg::OP_LOD || op_reg == pm0_pkg::OP_STO)
                    chk_fault = pm0_pkg::addr_fault(walk_a, DEPTH_S);
            end
            pm0_pkg::S_RET1:
                chk_fault = pm0_pkg::addr_fault(ret_nb, DEPTH_S);
            default:
                chk_fault = pm0_pkg::FLT_NONE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pm0_pkg::S_CLEAR:
                if (clr_reg == SB_W'(STACK_DEPTH - 1)) state_next = pm0_pkg::S_IDLE;
            pm0_pkg::S_IDLE:
                if (in_valid) state_next = pm0_pkg::S_DEC;
            pm0_pkg::S_DEC:
            begin
                state_next = pm0_pkg::S_TOP;
                if (!halt_reg && chk_fault == pm0_pkg::FLT_NONE)
                begin
                    case (op_reg)
                        pm0_pkg::OP_OPR:
                        begin
                            if (m_reg == pm0_pkg::OPR_RET)
                                state_next = pm0_pkg::S_RET1;
                            else if (is_un)
                                state_next = pm0_pkg::S_UN;
                            else if (is_bin)
                                state_next = pm0_pkg::S_BIN1;
                        end
                        pm0_pkg::OP_LOD, pm0_pkg::OP_STO, pm0_pkg::OP_CAL:
                            state_next = pm0_pkg::S_WALK;
                        pm0_pkg::OP_JPC, pm0_pkg::OP_WRITE:
                            state_next = pm0_pkg::S_JW;
                        default:
                            state_next = pm0_pkg::S_TOP;
                    endcase
                end
            end
            pm0_pkg::S_WALK:
            begin
                if (chk_fault != pm0_pkg::FLT_NONE)
                    state_next = pm0_pkg::S_TOP;
                else if (cnt_reg != 4'd0)
                    state_next = pm0_pkg::S_WALK_RD;
                else if (op_reg == pm0_pkg::OP_LOD)
                    state_next = pm0_pkg::S_LOD_WR;
                else if (op_reg == pm0_pkg::OP_STO)
                    state_next = pm0_pkg::S_STO_WR;
                else
                    state_next = pm0_pkg::S_CAL2;
            end
            pm0_pkg::S_WALK_RD: state_next = pm0_pkg::S_WALK;
            pm0_pkg::S_CAL2:    state_next = pm0_pkg::S_CAL3;
            pm0_pkg::S_CAL3:    state_next = pm0_pkg::S_CAL4;
            pm0_pkg::S_RET1:
                state_next = (chk_fault != pm0_pkg::FLT_NONE) ? pm0_pkg::S_TOP
                                                             : pm0_pkg::S_RET2;
            pm0_pkg::S_BIN1:    state_next = pm0_pkg::S_BIN2;
            pm0_pkg::S_BIN2:
            begin
                if ((m_reg == pm0_pkg::OPR_DIV || m_reg == pm0_pkg::OPR_MOD) &&
                    rop_reg != 32'd0)
                    state_next = pm0_pkg::S_DIV;
                else
                    state_next = pm0_pkg::S_TOP;
            end
            pm0_pkg::S_DIV:
                if (dcnt_reg == 5'd31) state_next = pm0_pkg::S_DIV_END;
            pm0_pkg::S_TOP:
            begin
                if (!pv_reg && sp_reg < SP_W'(STACK_DEPTH))
                    state_next = pm0_pkg::S_TOP_RD;
                else
                    state_next = pm0_pkg::S_FIN;
            end
            pm0_pkg::S_TOP_RD:  state_next = pm0_pkg::S_FIN;
            pm0_pkg::S_FIN:
                if (!ovalid_reg || !out_stall) state_next = pm0_pkg::S_IDLE;
            pm0_pkg::S_LOD_WR, pm0_pkg::S_STO_WR, pm0_pkg::S_CAL4, pm0_pkg::S_RET2,
            pm0_pkg::S_UN, pm0_pkg::S_DIV_END, pm0_pkg::S_JW:
                state_next = pm0_pkg::S_TOP;
            default:
                state_next = pm0_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        logic signed [31:0] lv_s;
        logic signed [31:0] rv_s;
        logic [31:0]        bin_v;
        logic [32:0]        rem_sh;
        logic [31:0]        l_abs;
        logic [31:0]        r_abs;

        op_next    = op_reg;
        fault_next = fault_reg;
        pc_next    = pc_reg;
        bp_next    = bp_reg;
        sp_next    = sp_reg;
        halt_next  = halt_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        rv_next    = rv_reg;
        b_next     = b_reg;
        addr_next  = addr_reg;
        rop_next   = rop_reg;
        pv_next    = pv_reg;
        tv_next    = tv_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        negq_next  = negq_reg;
        negr_next  = negr_reg;
        clr_next   = clr_reg;

        ovalid_next = ovalid_reg;
        opc_next    = opc_reg;
        obp_next    = obp_reg;
        osp_next    = osp_reg;
        otv_next    = otv_reg;
        opv_next    = opv_reg;
        ohalt_next  = ohalt_reg;
        oflt_next   = oflt_reg;

        mem_we    = 1'b0;
        mem_waddr = sp_reg[SB_W-1:0];
        mem_wdata = 32'd0;
        mem_raddr = sp_reg[SB_W-1:0];

        lv_s   = signed'(mem_rdata_reg);
        rv_s   = signed'(rop_reg);
        bin_v  = 32'd0;
        rem_sh = {rem_reg[31:0], quo_reg[31]};
        l_abs  = mem_rdata_reg[31] ? (32'd0 - mem_rdata_reg) : mem_rdata_reg;
        r_abs  = rop_reg[31] ? (32'd0 - rop_reg) : rop_reg;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        if (chk_fault != pm0_pkg::FLT_NONE)
            fault_next = chk_fault;

        case (state_reg)
            pm0_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + SB_W'(1);
            end
            pm0_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = pm0_pkg::op_t'(command);
                    m_next     = operand;
                    rv_next    = read_value;
                    fault_next = pm0_pkg::FLT_NONE;
                    pv_next    = 1'b0;
                    b_next     = signed'({{(pm0_pkg::EXT_W - SB_W){1'b0}}, bp_reg});
                    if (int'(level) > MAX_LEVEL)
                        cnt_next = 4'(MAX_LEVEL);
                    else
                        cnt_next = level;
                    if (!halt_reg)
                        pc_next = (pc_reg == PC_W'(CODE_DEPTH - 1)) ? '0
                                                                    : pc_reg + PC_W'(1);
                end
            end
            pm0_pkg::S_DEC:
            begin
                if (!halt_reg && chk_fault == pm0_pkg::FLT_NONE)
                begin
                    case (op_reg)
                        pm0_pkg::OP_LIT, pm0_pkg::OP_READ:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = sp_m1[SB_W-1:0];
                            mem_wdata = (op_reg == pm0_pkg::OP_LIT) ? m_reg : rv_reg;
                            sp_next   = sp_m1;
                        end
                        pm0_pkg::OP_OPR:
                            if (m_reg == pm0_pkg::OPR_RET)
                                mem_raddr = bp_reg - SB_W'(2);
                        pm0_pkg::OP_INC:
                            sp_next = inc_a[SP_W-1:0];
                        pm0_pkg::OP_JMP:
                            pc_next = m_reg[PC_W-1:0];
                        pm0_pkg::OP_HALT:
                            halt_next = 1'b1;
                        default:
                            mem_raddr = sp_reg[SB_W-1:0];
                    endcase
                end
            end
            pm0_pkg::S_WALK:
            begin
                if (chk_fault == pm0_pkg::FLT_NONE)
                begin
                    if (cnt_reg != 4'd0)
                        mem_raddr = walk_prev[SB_W-1:0];
                    else if (op_reg == pm0_pkg::OP_LOD)
                        mem_raddr = walk_a[SB_W-1:0];
                    else if (op_reg == pm0_pkg::OP_STO)
                    begin
                        addr_next = walk_a[SB_W-1:0];
                        mem_raddr = sp_reg[SB_W-1:0];
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_m1[SB_W-1:0];
                        mem_wdata = 32'd0;
                    end
                end
            end
            pm0_pkg::S_WALK_RD:
            begin
                b_next   = ret_nb;
                cnt_next = cnt_reg - 4'd1;
            end
            pm0_pkg::S_LOD_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sp_m1[SB_W-1:0];
                mem_wdata = mem_rdata_reg;
                sp_next   = sp_m1;
            end
            pm0_pkg::S_STO_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = mem_rdata_reg;
                sp_next   = sp_p1;
            end
            pm0_pkg::S_CAL2:
            begin
                mem_we    = 1'b1;
                mem_waddr = sp_reg[SB_W-1:0] - SB_W'(2);
                mem_wdata = b_reg[31:0];
            end
            pm0_pkg::S_CAL3:
            begin
                mem_we    = 1'b1;
                mem_waddr = sp_reg[SB_W-1:0] - SB_W'(3);
                mem_wdata = 32'(bp_reg);
            end
            pm0_pkg::S_CAL4:
            begin
                mem_we    = 1'b1;
                mem_waddr = sp_reg[SB_W-1:0] - SB_W'(4);
                mem_wdata = 32'(pc_reg);
                bp_next   = sp_m1[SB_W-1:0];
                pc_next   = m_reg[PC_W-1:0];
            end
            pm0_pkg::S_RET1:
            begin
                b_next    = ret_nb;
                mem_raddr = bp_reg - SB_W'(3);
            end
            pm0_pkg::S_RET2:
            begin
                pc_next = mem_rdata_reg[PC_W-1:0];
                sp_next = SP_W'(bp_reg) + SP_W'(1);
                bp_next = b_reg[SB_W-1:0];
            end
            pm0_pkg::S_UN:
            begin
                mem_we    = 1'b1;
                mem_waddr = sp_reg[SB_W-1:0];
                mem_wdata = (m_reg == pm0_pkg::OPR_NEG) ? (32'd0 - mem_rdata_reg)
                                                        : {31'd0, mem_rdata_reg[0]};
            end
            pm0_pkg::S_BIN1:
            begin
                rop_next  = mem_rdata_reg;
                mem_raddr = sp_p1[SB_W-1:0];
            end
            pm0_pkg::S_BIN2:
            begin
                case (m_reg)
                    pm0_pkg::OPR_ADD: bin_v = mem_rdata_reg + rop_reg;
                    pm0_pkg::OPR_SUB: bin_v = mem_rdata_reg - rop_reg;
                    pm0_pkg::OPR_MUL: bin_v = mem_rdata_reg * rop_reg;
                    pm0_pkg::OPR_EQL: bin_v = {31'd0, lv_s == rv_s};
                    pm0_pkg::OPR_NEQ: bin_v = {31'd0, lv_s != rv_s};
                    pm0_pkg::OPR_LSS: bin_v = {31'd0, lv_s <  rv_s};
                    pm0_pkg::OPR_LEQ: bin_v = {31'd0, lv_s <= rv_s};
                    pm0_pkg::OPR_GTR: bin_v = {31'd0, lv_s >  rv_s};
                    pm0_pkg::OPR_GEQ: bin_v = {31'd0, lv_s >= rv_s};
                    default:          bin_v = 32'd0;
                endcase
                if ((m_reg == pm0_pkg::OPR_DIV || m_reg == pm0_pkg::OPR_MOD) &&
                    rop_reg != 32'd0)
                begin
                    rem_next  = 33'd0;
                    quo_next  = l_abs;
                    rop_next  = r_abs;
                    negq_next = mem_rdata_reg[31] ^ rop_reg[31];
                    negr_next = mem_rdata_reg[31];
                    dcnt_next = 5'd0;
                end
                else
                begin
                    if (m_reg == pm0_pkg::OPR_DIV || m_reg == pm0_pkg::OPR_MOD)
                        fault_next = pm0_pkg::FLT_DIV0;
                    mem_we    = 1'b1;
                    mem_waddr = sp_p1[SB_W-1:0];
                    mem_wdata = bin_v;
                    sp_next   = sp_p1;
                end
            end
            pm0_pkg::S_DIV:
            begin
                if (rem_sh >= {1'b0, rop_reg})
                begin
                    rem_next = rem_sh - {1'b0, rop_reg};
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
            end
            pm0_pkg::S_DIV_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = sp_p1[SB_W-1:0];
                if (m_reg == pm0_pkg::OPR_MOD)
                    mem_wdata = negr_reg ? (32'd0 - rem_reg[31:0]) : rem_reg[31:0];
                else
                    mem_wdata = negq_reg ? (32'd0 - quo_reg) : quo_reg;
                sp_next = sp_p1;
            end
            pm0_pkg::S_JW:
            begin
                if (op_reg == pm0_pkg::OP_WRITE)
                begin
                    pv_next = 1'b1;
                    tv_next = mem_rdata_reg;
                end
                else if (mem_rdata_reg == 32'd0)
                    pc_next = m_reg[PC_W-1:0];
                sp_next = sp_p1;
            end
            pm0_pkg::S_TOP:
            begin
                mem_raddr = sp_reg[SB_W-1:0];
                if (!pv_reg && sp_reg >= SP_W'(STACK_DEPTH))
                    tv_next = 32'd0;
            end
            pm0_pkg::S_TOP_RD:
                tv_next = mem_rdata_reg;
            pm0_pkg::S_FIN:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    opc_next    = pc_reg;
                    obp_next    = bp_reg;
                    osp_next    = sp_reg;
                    otv_next    = tv_reg;
                    opv_next    = pv_reg;
                    ohalt_next  = halt_reg;
                    oflt_next   = fault_reg;
                end
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pm0_pkg::S_CLEAR;
            clr_reg    <= '0;
            pc_reg     <= '0;
            bp_reg     <= SB_W'(STACK_DEPTH - 1);
            sp_reg     <= SP_W'(STACK_DEPTH);
            halt_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            dcnt_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            bp_reg     <= bp_next;
            sp_reg     <= sp_next;
            halt_reg   <= halt_next;
            ovalid_reg <= ovalid_next;
            dcnt_reg   <= dcnt_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        fault_reg <= fault_next;
        m_reg     <= m_next;
        rv_reg    <= rv_next;
        b_reg     <= b_next;
        addr_reg  <= addr_next;
        rop_reg   <= rop_next;
        pv_reg    <= pv_next;
        tv_reg    <= tv_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        negq_reg  <= negq_next;
        negr_reg  <= negr_next;
        opc_reg   <= opc_next;
        obp_reg   <= obp_next;
        osp_reg   <= osp_next;
        otv_reg   <= otv_next;
        opv_reg   <= opv_next;
        ohalt_reg <= ohalt_next;
        oflt_reg  <= oflt_next;
    end

    assign in_stall    = (state_reg != pm0_pkg::S_IDLE);
    assign out_valid   = ovalid_reg;
    assign next_pc     = opc_reg;
    assign frame_base  = obp_reg;
    assign stack_index = osp_reg;
    assign top_value   = signed'(otv_reg);
    assign print_valid = opv_reg;
    assign halted      = ohalt_reg;
    assign fault       = oflt_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pm0_pkg::S_IDLE |-> !mem_we)
        else $error("stack write while idle");

    a_print_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && print_valid) |-> (fault == pm0_pkg::FLT_NONE))
        else $error("write request with fault");

endmodule

// File: tb/tb_pm0_stack_machine_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pm0_stack_machine_execute_core
// Self-checking bench for the PM/0 execute core. A scoreboard class mirrors
// the machine state, predicts one result per accepted request and compares
// every result field by field. Directed corner cases come first, then
// mostly well-formed random programs with some noise and a final halt.
// ----------------------------------------------------------------------------
module tb_pm0_stack_machine_execute_core;

    localparam int DEPTH     = 1024;
    localparam int N_RANDOM  = 1950;
    localparam int LIMIT     = 600000;

    typedef struct packed {
        logic [8:0]  pc;
        logic [9:0]  bp;
        logic [10:0] sp;
        logic [31:0] top;
        logic        pv;
        logic        hl;
        logic [1:0]  flt;
    } machine_result_t;

    class pm0_scoreboard;
        logic [31:0]     stk [DEPTH];
        logic [8:0]      pc;
        int              bp;
        int              sp;
        bit              hlt;
        machine_result_t pending [$];
        int              errors;
        int              checked;
        int              faults;
        int              prints;

        function new();
            foreach (stk[i]) stk[i] = '0;
            pc = '0;
            bp = DEPTH - 1;
            sp = DEPTH;
            hlt = 0;
            errors = 0;
            checked = 0;
            faults = 0;
            prints = 0;
        endfunction

        function longint sx(logic [31:0] v);
            return longint'($signed(v));
        endfunction

        function pm0_pkg::fault_t range_fault(longint a);
            if (a < 0) return pm0_pkg::FLT_OVER;
            if (a >= DEPTH) return pm0_pkg::FLT_UNDER;
            return pm0_pkg::FLT_NONE;
        endfunction

        function pm0_pkg::fault_t follow_links(logic [3:0] lv, output longint b);
            int n;
            pm0_pkg::fault_t f;
            b = bp;
            n = (lv > 15) ? 15 : lv;
            while (n > 0) begin
                f = range_fault(b - 1);
                if (f != pm0_pkg::FLT_NONE) return f;
                b = sx(stk[b - 1]);
                n--;
            end
            return pm0_pkg::FLT_NONE;
        endfunction

        function pm0_pkg::fault_t arith(logic [31:0] sub);
            longint l, r, nb;
            logic [31:0] v;
            pm0_pkg::fault_t f;
            f = pm0_pkg::FLT_NONE;
            v = '0;
            case (sub)
                pm0_pkg::OPR_RET: begin
                    if (bp < 3) return pm0_pkg::FLT_OVER;
                    nb = sx(stk[bp - 2]);
                    f = range_fault(nb);
                    if (f != pm0_pkg::FLT_NONE) return f;
                    pc = stk[bp - 3][8:0];
                    sp = bp + 1;
                    bp = int'(nb);
                    return pm0_pkg::FLT_NONE;
                end
                pm0_pkg::OPR_NEG: begin
                    if (sp >= DEPTH) return pm0_pkg::FLT_UNDER;
                    stk[sp] = 32'd0 - stk[sp];
                    return pm0_pkg::FLT_NONE;
                end
                pm0_pkg::OPR_ODD: begin
                    if (sp >= DEPTH) return pm0_pkg::FLT_UNDER;
                    stk[sp] = stk[sp] & 32'd1;
                    return pm0_pkg::FLT_NONE;
                end
                pm0_pkg::OPR_ADD, pm0_pkg::OPR_SUB, pm0_pkg::OPR_MUL, pm0_pkg::OPR_DIV,
                pm0_pkg::OPR_MOD, pm0_pkg::OPR_EQL, pm0_pkg::OPR_NEQ, pm0_pkg::OPR_LSS,
                pm0_pkg::OPR_LEQ, pm0_pkg::OPR_GTR, pm0_pkg::OPR_GEQ: ;
                default: return pm0_pkg::FLT_NONE;
            endcase
            if (sp + 2 > DEPTH) return pm0_pkg::FLT_UNDER;
            r = sx(stk[sp]);
            l = sx(stk[sp + 1]);
            case (sub)
                pm0_pkg::OPR_ADD: v = stk[sp + 1] + stk[sp];
                pm0_pkg::OPR_SUB: v = stk[sp + 1] - stk[sp];
                pm0_pkg::OPR_MUL: v = stk[sp + 1] * stk[sp];
                pm0_pkg::OPR_DIV:
                    if (r == 0) f = pm0_pkg::FLT_DIV0; else v = 32'(l / r);
                pm0_pkg::OPR_MOD:
                    if (r == 0) f = pm0_pkg::FLT_DIV0; else v = 32'(l % r);
                pm0_pkg::OPR_EQL: v = 32'(l == r);
                pm0_pkg::OPR_NEQ: v = 32'(l != r);
                pm0_pkg::OPR_LSS: v = 32'(l < r);
                pm0_pkg::OPR_LEQ: v = 32'(l <= r);
                pm0_pkg::OPR_GTR: v = 32'(l > r);
                default: v = 32'(l >= r);
            endcase
            sp++;
            stk[sp] = v;
            return f;
        endfunction

        function void note_request(logic [3:0] op, logic [3:0] lv, logic [31:0] m,
                                   logic [31:0] rv);
            pm0_pkg::fault_t f;
            logic pv;
            logic [31:0] wv;
            longint b, a;
            machine_result_t e;
            f = pm0_pkg::FLT_NONE;
            pv = 0;
            wv = '0;
            b = 0;
            if (!hlt) begin
                pc = pc + 9'd1;
                case (op)
                    pm0_pkg::OP_LIT, pm0_pkg::OP_READ: begin
                        if (sp == 0) f = pm0_pkg::FLT_OVER;
                        else begin
                            sp--;
                            stk[sp] = (op == pm0_pkg::OP_LIT) ? m : rv;
                        end
                    end
                    pm0_pkg::OP_OPR: f = arith(m);
                    pm0_pkg::OP_LOD: begin
                        if (sp == 0) f = pm0_pkg::FLT_OVER;
                        else begin
                            f = follow_links(lv, b);
                            if (f == pm0_pkg::FLT_NONE) begin
                                a = b - sx(m);
                                f = range_fault(a);
                                if (f == pm0_pkg::FLT_NONE) begin
                                    sp--;
                                    stk[sp] = stk[a];
                                end
                            end
                        end
                    end
                    pm0_pkg::OP_STO: begin
                        if (sp >= DEPTH) f = pm0_pkg::FLT_UNDER;
                        else begin
                            f = follow_links(lv, b);
                            if (f == pm0_pkg::FLT_NONE) begin
                                a = b - sx(m);
                                f = range_fault(a);
                                if (f == pm0_pkg::FLT_NONE) begin
                                    stk[a] = stk[sp];
                                    sp++;
                                end
                            end
                        end
                    end
                    pm0_pkg::OP_CAL: begin
                        if (sp < 4) f = pm0_pkg::FLT_OVER;
                        else begin
                            f = follow_links(lv, b);
                            if (f == pm0_pkg::FLT_NONE) begin
                                stk[sp - 1] = '0;
                                stk[sp - 2] = 32'(b);
                                stk[sp - 3] = 32'(bp);
                                stk[sp - 4] = 32'(pc);
                                bp = sp - 1;
                                pc = m[8:0];
                            end
                        end
                    end
                    pm0_pkg::OP_INC: begin
                        a = longint'(sp) - sx(m);
                        if (a < 0) f = pm0_pkg::FLT_OVER;
                        else if (a > DEPTH) f = pm0_pkg::FLT_UNDER;
                        else sp = int'(a);
                    end
                    pm0_pkg::OP_JMP: pc = m[8:0];
                    pm0_pkg::OP_JPC: begin
                        if (sp >= DEPTH) f = pm0_pkg::FLT_UNDER;
                        else begin
                            if (stk[sp] == 0) pc = m[8:0];
                            sp++;
                        end
                    end
                    pm0_pkg::OP_WRITE: begin
                        if (sp >= DEPTH) f = pm0_pkg::FLT_UNDER;
                        else begin
                            pv = 1;
                            wv = stk[sp];
                            sp++;
                        end
                    end
                    pm0_pkg::OP_HALT: hlt = 1;
                    default: ;
                endcase
            end
            if (!pv) wv = (sp < DEPTH) ? stk[sp] : '0;
            e.pc = pc;
            e.bp = 10'(bp);
            e.sp = 11'(sp);
            e.top = wv;
            e.pv = pv;
            e.hl = hlt;
            e.flt = f;
            pending.push_back(e);
        endfunction

        function void check_result(machine_result_t got);
            machine_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected: %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.flt != pm0_pkg::FLT_NONE) faults++;
            if (got.pv) prints++;
            if (got.pc !== e.pc) begin
                $display("%0t: next_pc expected %0d actual %0d", $time, e.pc, got.pc);
                errors++;
            end
            if (got.bp !== e.bp) begin
                $display("%0t: frame_base expected %0d actual %0d", $time, e.bp, got.bp);
                errors++;
            end
            if (got.sp !== e.sp) begin
                $display("%0t: stack_index expected %0d actual %0d", $time, e.sp, got.sp);
                errors++;
            end
            if (got.top !== e.top) begin
                $display("%0t: top_value expected %h actual %h", $time, e.top, got.top);
                errors++;
            end
            if (got.pv !== e.pv) begin
                $display("%0t: print_valid expected %b actual %b", $time, e.pv, got.pv);
                errors++;
            end
            if (got.hl !== e.hl) begin
                $display("%0t: halted expected %b actual %b", $time, e.hl, got.hl);
                errors++;
            end
            if (got.flt !== e.flt) begin
                $display("%0t: fault expected %0d actual %0d", $time, e.flt, got.flt);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         command;
    logic [3:0]         level;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;
    logic               out_valid;
    logic               out_stall;
    logic [8:0]         next_pc;
    logic [9:0]         frame_base;
    logic [10:0]        stack_index;
    logic signed [31:0] top_value;
    logic               print_valid;
    logic               halted;
    logic [1:0]         fault;

    pm0_scoreboard sb;
    bit            steady;
    int            cycles;
    int            n_sent;

    pm0_stack_machine_execute_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .level       (level),
        .operand     (operand),
        .read_value  (read_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .frame_base  (frame_base),
        .stack_index (stack_index),
        .top_value   (top_value),
        .print_valid (print_valid),
        .halted      (halted),
        .fault       (fault)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: check, then stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({next_pc, frame_base, stack_index, top_value,
                             print_valid, halted, fault});
        out_stall <= !steady && ($urandom_range(0, 99) < 13);
    end

    task automatic send_request(logic [3:0] op, logic [3:0] lv, logic [31:0] m);
        logic [31:0] rv;
        rv = $urandom;
        if (!steady && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= op;
        level      <= lv;
        operand    <= m;
        read_value <= rv;
        do @(posedge clk); while (in_stall);
        sb.note_request(op, lv, m, rv);
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_literal();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            3, 4: return 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        logic [3:0]  op;
        logic [3:0]  lv;
        logic [31:0] m;
        int          k;
        k  = $urandom_range(0, 99);
        lv = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 2));
        m  = 32'($urandom_range(0, 8)) - 32'd3;
        if (k < 6)
        begin
            op = 4'($urandom_range(0, 15));
            lv = 4'($urandom_range(0, 15));
            m  = $urandom;
        end
        else if (k < 28) begin op = pm0_pkg::OP_LIT; m = pick_literal(); end
        else if (k < 34) op = pm0_pkg::OP_READ;
        else if (k < 44) op = pm0_pkg::OP_LOD;
        else if (k < 54) op = pm0_pkg::OP_STO;
        else if (k < 76)
        begin
            op = pm0_pkg::OP_OPR;
            m  = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(1, 13));
        end
        else if (k < 79) begin op = pm0_pkg::OP_OPR; m = pm0_pkg::OPR_RET; end
        else if (k < 83) begin op = pm0_pkg::OP_CAL; m = $urandom; end
        else if (k < 87) op = pm0_pkg::OP_INC;
        else if (k < 90) begin op = pm0_pkg::OP_JMP; m = $urandom; end
        else if (k < 94) begin op = pm0_pkg::OP_JPC; m = $urandom; end
        else op = pm0_pkg::OP_WRITE;
        // keep the stack from pinning at either end
        if (op != pm0_pkg::OP_OPR && op != pm0_pkg::OP_CAL && op != pm0_pkg::OP_INC &&
            k >= 6)
        begin
            if (sb.sp < 64 && (op == pm0_pkg::OP_LIT || op == pm0_pkg::OP_READ ||
                               op == pm0_pkg::OP_LOD))
                op = pm0_pkg::OP_WRITE;
            else if (sb.sp > 1016 && (op == pm0_pkg::OP_STO || op == pm0_pkg::OP_WRITE ||
                                      op == pm0_pkg::OP_JPC))
                op = pm0_pkg::OP_LIT;
        end
        if (op == pm0_pkg::OP_HALT)
            op = pm0_pkg::OP_JMP;
        send_request(op, lv, m);
    endtask

    initial
    begin
        sb         = new();
        cycles     = 0;
        n_sent     = 0;
        steady     = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = '0;
        level      = '0;
        operand    = '0;
        read_value = '0;
        out_stall  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, wraps, min/-1, divide by zero, odd, unknown codes
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_ADD);
        send_request(pm0_pkg::OP_WRITE, 4'd0, 32'd0);
        send_request(pm0_pkg::OP_JPC, 4'd0, 32'd7);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'h7fffffff);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'd1);
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_ADD);
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_NEG);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'h80000000);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'hffffffff);
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_DIV);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'h80000000);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'hffffffff);
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_MOD);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'd0);
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_MOD);
        send_request(pm0_pkg::OP_LIT, 4'd0, 32'hfffffffd);
        send_request(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_ODD);
        send_request(pm0_pkg::OP_NONE, 4'd15, 32'hffffffff);
        send_request(4'd15, 4'd0, 32'd0);
        send_request(pm0_pkg::OP_OPR, 4'd0, 32'd14);
        send_request(pm0_pkg::OP_INC, 4'd0, 32'hfffff830);
        send_request(pm0_pkg::OP_LOD, 4'd15, 32'd0);
        send_request(pm0_pkg::OP_STO, 4'd1, 32'd3);
        send_request(pm0_pkg::OP_CAL, 4'd2, 32'd100);
        send_request(pm0_pkg::OP_READ, 4'd0, 32'd0);
        send_request(pm0_pkg::OP_JMP, 4'd0, 32'hffffffff);

        // hold until the core has caught up
        drain_results();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            steady = (i >= 800 && i < 1100);
            random_request();
        end
        steady = 0;

        send_request(pm0_pkg::OP_HALT, 4'd0, 32'd0);
        repeat (3) send_request(pm0_pkg::OP_LIT, 4'($urandom), $urandom);

        drain_results();
        $display("%0d requests, %0d results checked, %0d faults, %0d writes",
                 n_sent, sb.checked, sb.faults, sb.prints);
        $display("directed corners, random programs with frames and noise, halt");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
src/pm0_pkg.sv
src/pm0_stack_machine_execute_core.sv
tb/tb_pm0_stack_machine_execute_core.sv
